/* rtl/core/bdq_pkg.sv */
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_COUNT      = 3'd4,
		REQ_DUMP_FWD   = 3'd5,
		REQ_DUMP_REV   = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_RDOUT
	} state_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

endpackage

/* rtl/core/bdq_if.sv */
// Request and response channel interfaces of the deque.
interface bdq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           req_type;
	logic signed [bdq_pkg::VALUE_W-1:0]   item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface bdq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic signed [bdq_pkg::VALUE_W-1:0]   out_value;
	logic [bdq_pkg::COUNT_W-1:0]          match_count;
	logic [bdq_pkg::COUNT_W-1:0]          occupancy;
	logic                                 last;

	modport source (output valid, output status, output out_value, output match_count,
		output occupancy, output last, input ready);
	modport sink   (input valid, input status, input out_value, input match_count,
		input occupancy, input last, output ready);
endinterface

/* rtl/core/bounded_deque_with_search_top.sv */
// Bounded deque controller: ring pointers, request sequencer and response register.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | req_type, item_value
//  rsp     | out | valid/ready | status, out_value, match_count, occupancy, last
//
// One request at a time. Push, refused requests and unused codes respond from the
// sequencer directly; pop reads its entry first. Count does one RAM read per entry.
// Dump gives one response per cycle while rsp is not stalled, paced by the RAM read port.
// No clearing pass after reset; stalls on rsp hold the sequencer and the RAM read data.
module bounded_deque_with_search_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	bdq_req_if.sink      req,
	bdq_rsp_if.source    rsp
);

	localparam int unsigned IDXW = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned VW   = bdq_pkg::VALUE_W;
	localparam int unsigned OW   = bdq_pkg::COUNT_W;
	localparam logic [IDXW:0]   DEPTH_W  = (IDXW + 1)'(DEPTH);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);
	localparam logic [CW-1:0]   FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0]   ONE_CNT  = CW'(1);

	function automatic logic [IDXW-1:0] slot(input logic [IDXW-1:0] base,
		input logic [IDXW-1:0] off);
		logic [IDXW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[IDXW-1:0];
	endfunction

	bdq_pkg::state_t state_q, state_d;
	bdq_pkg::req_t   req_q;
	logic [VW-1:0]   key_q;

	logic [IDXW-1:0] front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IDXW-1:0] off_q, off_d;
	logic [CW-1:0]   rem_q, rem_d;
	logic [CW-1:0]   iss_q, iss_d;
	logic [CW-1:0]   hits_q, hits_d;
	logic            cmp_s1, cmp_d;

	logic            out_valid_q;
	logic            out_free;
	logic            emit;
	bdq_pkg::status_t emit_status;
	logic [VW-1:0]   emit_value;
	logic [CW-1:0]   emit_match;
	logic            emit_last;

	logic [1:0]      status_q;
	logic [VW-1:0]   value_q;
	logic [OW-1:0]   match_q;
	logic [OW-1:0]   occ_q;
	logic            last_q;

	logic            ram_we;
	logic [IDXW-1:0] ram_waddr;
	logic            ram_re;
	logic [IDXW-1:0] ram_raddr;
	logic [VW-1:0]   ram_rdata;

	bdq_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == bdq_pkg::ST_IDLE);

	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		count_d     = count_q;
		off_d       = off_q;
		rem_d       = rem_q;
		iss_d       = iss_q;
		hits_d      = hits_q;
		cmp_d       = 1'b0;
		emit        = 1'b0;
		emit_status = bdq_pkg::STAT_OK;
		emit_value  = '0;
		emit_match  = '0;
		emit_last   = 1'b1;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;

		case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = bdq_pkg::ST_EXEC;
				end
			end
			bdq_pkg::ST_EXEC: begin
				if (out_free) begin
					case (req_q)
						bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
							emit    = 1'b1;
							state_d = bdq_pkg::ST_IDLE;
							if (count_q == FULL_CNT) begin
								emit_status = bdq_pkg::STAT_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + ONE_CNT;
								if (req_q == bdq_pkg::REQ_PUSH_FRONT) begin
									front_d   = (front_q == '0) ? LAST_IDX : front_q - IDXW'(1);
									ram_waddr = front_d;
								end else begin
									ram_waddr = slot(front_q, IDXW'(count_q));
								end
							end
						end
						bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = bdq_pkg::STAT_EMPTY;
								state_d     = bdq_pkg::ST_IDLE;
							end else begin
								ram_re  = 1'b1;
								count_d = count_q - ONE_CNT;
								rem_d   = ONE_CNT;
								state_d = bdq_pkg::ST_RDOUT;
								if (req_q == bdq_pkg::REQ_POP_FRONT) begin
									ram_raddr = front_q;
									front_d   = slot(front_q, IDXW'(1));
								end else begin
									ram_raddr = slot(front_q, IDXW'(count_q - ONE_CNT));
								end
							end
						end
						bdq_pkg::REQ_COUNT: begin
							iss_d  = '0;
							hits_d = '0;
							if (count_q == '0) begin
								emit    = 1'b1;
								state_d = bdq_pkg::ST_IDLE;
							end else begin
								state_d = bdq_pkg::ST_SCAN;
							end
						end
						bdq_pkg::REQ_DUMP_FWD, bdq_pkg::REQ_DUMP_REV: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = bdq_pkg::STAT_EMPTY;
								state_d     = bdq_pkg::ST_IDLE;
							end else begin
								ram_re  = 1'b1;
								rem_d   = count_q;
								state_d = bdq_pkg::ST_RDOUT;
								if (req_q == bdq_pkg::REQ_DUMP_FWD) begin
									ram_raddr = front_q;
									off_d     = IDXW'(1);
								end else begin
									ram_raddr = slot(front_q, IDXW'(count_q - ONE_CNT));
									off_d     = IDXW'(count_q - ONE_CNT) - IDXW'(1);
								end
							end
						end
						default: begin
							emit    = 1'b1;
							state_d = bdq_pkg::ST_IDLE;
						end
					endcase
				end
			end
			bdq_pkg::ST_SCAN: begin
				if (cmp_s1 && ram_rdata == key_q) begin
					hits_d = hits_q + ONE_CNT;
				end
				if (iss_q != count_q) begin
					ram_re    = 1'b1;
					ram_raddr = slot(front_q, IDXW'(iss_q));
					iss_d     = iss_q + ONE_CNT;
					cmp_d     = 1'b1;
				end else if (!cmp_s1 && out_free) begin
					emit       = 1'b1;
					emit_match = hits_q;
					state_d    = bdq_pkg::ST_IDLE;
				end
			end
			bdq_pkg::ST_RDOUT: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_value = ram_rdata;
					emit_last  = (rem_q == ONE_CNT);
					if (rem_q == ONE_CNT) begin
						state_d = bdq_pkg::ST_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = slot(front_q, off_q);
						rem_d     = rem_q - ONE_CNT;
						off_d     = (req_q == bdq_pkg::REQ_DUMP_FWD) ? off_q + IDXW'(1)
							: off_q - IDXW'(1);
					end
				end
			end
			default: begin
				state_d = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			off_q       <= '0;
			rem_q       <= '0;
			iss_q       <= '0;
			hits_q      <= '0;
			cmp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			off_q   <= off_d;
			rem_q   <= rem_d;
			iss_q   <= iss_d;
			hits_q  <= hits_d;
			cmp_s1  <= cmp_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= bdq_pkg::req_t'(req.req_type);
			key_q <= req.item_value;
		end
		if (emit) begin
			status_q <= emit_status;
			value_q  <= emit_value;
			match_q  <= OW'(emit_match);
			occ_q    <= OW'(count_d);
			last_q   <= emit_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.out_value   = value_q;
	assign rsp.match_count = match_q;
	assign rsp.occupancy   = occ_q;
	assign rsp.last        = last_q;

endmodule

/* rtl/core/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the bounded deque: directed, back-pressure and randomized traffic.
module tb;

	localparam int unsigned DEPTH       = 16;
	localparam logic [2:0]  REQ_UNUSED  = 3'd7;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN_PAD   = DEPTH + 8;
	localparam logic [31:0] FILL_KEY    = 32'hFFFF_FFFB;

	typedef struct {
		bdq_pkg::status_t status;
		logic [31:0]      value;
		logic [4:0]       match_cnt;
		logic [4:0]       occupancy;
		logic             last;
	} deque_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search_top #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	logic [31:0]  ring [DEPTH];
	int unsigned  head_slot;
	int unsigned  fill;
	deque_rsp_t   pending_rsp_q [$];
	logic [31:0]  key_pool [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

	int err_count;
	int n_reqs;
	int n_rsps;
	int n_full;
	int n_empty;
	int send_idle_pct;
	int stall_pct;
	bit hold_start;
	int hold_left;

	function automatic void expect_rsp(bdq_pkg::status_t st, logic [31:0] v, int unsigned hits,
		logic fin);
		deque_rsp_t r;
		r.status    = st;
		r.value     = v;
		r.match_cnt = hits[4:0];
		r.occupancy = fill[4:0];
		r.last      = fin;
		pending_rsp_q.push_back(r);
	endfunction

	function automatic void deque_step(logic [2:0] code, logic [31:0] value);
		int unsigned hits;
		int unsigned i;
		int unsigned off;
		logic [31:0] popped;
		n_reqs++;
		case (code)
			bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					n_full++;
					expect_rsp(bdq_pkg::STAT_FULL, '0, 0, 1'b1);
				end else begin
					if (code == bdq_pkg::REQ_PUSH_FRONT) begin
						head_slot = (head_slot + DEPTH - 1) % DEPTH;
						ring[head_slot] = value;
					end else begin
						ring[(head_slot + fill) % DEPTH] = value;
					end
					fill++;
					expect_rsp(bdq_pkg::STAT_OK, '0, 0, 1'b1);
				end
			end
			bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
				if (fill == 0) begin
					n_empty++;
					expect_rsp(bdq_pkg::STAT_EMPTY, '0, 0, 1'b1);
				end else begin
					if (code == bdq_pkg::REQ_POP_FRONT) begin
						popped = ring[head_slot];
						head_slot = (head_slot + 1) % DEPTH;
					end else begin
						popped = ring[(head_slot + fill - 1) % DEPTH];
					end
					fill--;
					expect_rsp(bdq_pkg::STAT_OK, popped, 0, 1'b1);
				end
			end
			bdq_pkg::REQ_COUNT: begin
				hits = 0;
				for (i = 0; i < fill; i++)
					if (ring[(head_slot + i) % DEPTH] == value)
						hits++;
				expect_rsp(bdq_pkg::STAT_OK, '0, hits, 1'b1);
			end
			bdq_pkg::REQ_DUMP_FWD, bdq_pkg::REQ_DUMP_REV: begin
				if (fill == 0) begin
					n_empty++;
					expect_rsp(bdq_pkg::STAT_EMPTY, '0, 0, 1'b1);
				end else begin
					for (i = 0; i < fill; i++) begin
						off = (code == bdq_pkg::REQ_DUMP_FWD) ? i : fill - 1 - i;
						expect_rsp(bdq_pkg::STAT_OK, ring[(head_slot + off) % DEPTH], 0,
							i + 1 == fill);
					end
				end
			end
			default: expect_rsp(bdq_pkg::STAT_OK, '0, 0, 1'b1);
		endcase
	endfunction

	always @(posedge clk) begin
		deque_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response with no request outstanding: status %0d out_value %0d",
					rsp_ch.status, rsp_ch.out_value);
				err_count++;
			end else begin
				want = pending_rsp_q.pop_front();
				n_rsps++;
				if (rsp_ch.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.out_value !== want.value) begin
					$error("out_value expected %0d got %0d", $signed(want.value),
						rsp_ch.out_value);
					err_count++;
				end
				if (rsp_ch.match_count !== want.match_cnt) begin
					$error("match_count expected %0d got %0d", want.match_cnt,
						rsp_ch.match_count);
					err_count++;
				end
				if (rsp_ch.occupancy !== want.occupancy) begin
					$error("occupancy expected %0d got %0d", want.occupancy, rsp_ch.occupancy);
					err_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last expected %0d got %0d", want.last, rsp_ch.last);
					err_count++;
				end
			end
		end
	end

	// Response side: long hold-off when requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_req(input logic [2:0] code, input logic [31:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= code;
		req_ch.item_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		deque_step(code, value);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 40)
			return key_pool[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_code(int push_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return REQ_UNUSED;
		if (r < 12)
			return bdq_pkg::REQ_COUNT;
		if (r < 18)
			return $urandom_range(0, 1) ? bdq_pkg::REQ_DUMP_FWD : bdq_pkg::REQ_DUMP_REV;
		if ($urandom_range(0, 99) < push_bias)
			return $urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_BACK;
		return $urandom_range(0, 1) ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_POP_BACK;
	endfunction

	task automatic test_directed_ops();
		send_req(bdq_pkg::REQ_POP_FRONT, 32'h0);
		send_req(bdq_pkg::REQ_POP_BACK, 32'h0);
		send_req(bdq_pkg::REQ_DUMP_FWD, 32'h0);
		send_req(bdq_pkg::REQ_DUMP_REV, 32'h0);
		send_req(bdq_pkg::REQ_COUNT, 32'h0);
		send_req(REQ_UNUSED, 32'h0);
		send_req(bdq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
		send_req(bdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
		send_req(bdq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
		send_req(bdq_pkg::REQ_COUNT, 32'h8000_0000);
		send_req(bdq_pkg::REQ_DUMP_FWD, 32'h0);
		send_req(bdq_pkg::REQ_DUMP_REV, 32'h0);
		send_req(bdq_pkg::REQ_POP_FRONT, 32'h0);
		send_req(bdq_pkg::REQ_POP_BACK, 32'h0);
		send_req(bdq_pkg::REQ_POP_BACK, 32'h0);
		wait_drained();
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < DEPTH; i++)
			send_req(i % 2 ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT, FILL_KEY);
		send_req(bdq_pkg::REQ_PUSH_FRONT, 32'h1);
		send_req(bdq_pkg::REQ_PUSH_BACK, 32'h2);
		send_req(bdq_pkg::REQ_COUNT, FILL_KEY);
		send_req(bdq_pkg::REQ_DUMP_FWD, 32'h0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_start = 1'b1;
		for (i = 0; i < 24; i++)
			send_req(pick_code(50), pick_value());
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int n_items);
		int i;
		send_idle_pct = idle;
		stall_pct = stall;
		for (i = 0; i < n_items; i++)
			send_req(pick_code(((i / 24) % 2) ? 20 : 80), pick_value());
		wait_drained();
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.req_type   = '0;
		req_ch.item_value = '0;
		arst_n            = 1'b0;
		hold_start        = 1'b0;
		hold_left         = 0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		err_count         = 0;
		n_reqs            = 0;
		n_rsps            = 0;
		n_full            = 0;
		n_empty           = 0;
		head_slot         = 0;
		fill              = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_full_queue();
		test_backpressure();
		test_random_traffic(0, 0, 75);
		test_random_traffic(76, 0, 75);
		test_random_traffic(0, 76, 75);
		test_random_traffic(35, 35, 75);

		$display("Checked %0d responses from %0d requests under free, sender-idle,",
			n_rsps, n_reqs);
		$display("receiver-stall and mixed pacing; %0d full and %0d empty refusals seen.",
			n_full, n_empty);
		if (err_count == 0 && pending_rsp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
